// ----- src/ccc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccc_pkg : clock calendar counter shared definitions
// Field widths, counter limits, reset values, register indexes and the
// packed result word.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int HUND_W  = 7;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;

    localparam logic [HUND_W-1:0]  HUND_MAX  = 7'd99;
    localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;

    localparam logic [HUND_W-1:0]  HUND_RST  = 7'd0;
    localparam logic [SEC_W-1:0]   SEC_RST   = 6'd0;
    localparam logic [MIN_W-1:0]   MIN_RST   = 6'd0;
    localparam logic [HOUR_W-1:0]  HOUR_RST  = 5'd12;
    localparam logic [DAY_W-1:0]   DAY_RST   = 5'd7;
    localparam logic [MONTH_W-1:0] MONTH_RST = 4'd6;
    localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd1993;

    localparam logic [DAY_W-1:0]  DAYS_IN_MONTH_RST = 5'd30;
    localparam logic [YEAR_W-1:0] YEAR_START_RST    = 14'd1993;
    localparam logic [YEAR_W-1:0] YEAR_LAST_RST     = 14'd2099;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DAYS_IN_MONTH = 2'd0,
        CFG_YEAR_START    = 2'd1,
        CFG_YEAR_LAST     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DAY_W-1:0]  days_in_month;
        logic [YEAR_W-1:0] year_start;
        logic [YEAR_W-1:0] year_last;
    } cfg_t;

    // first member lands in the top bits: hundredths ends up lowest
    typedef struct packed {
        logic [YEAR_W-1:0]  year_now;
        logic [MONTH_W-1:0] month_now;
        logic [DAY_W-1:0]   day_now;
        logic [HOUR_W-1:0]  hours_now;
        logic [MIN_W-1:0]   minutes_now;
        logic [SEC_W-1:0]   seconds_now;
        logic [HUND_W-1:0]  hundredths;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- src/clock_calendar_counter_top.sv -----
// ----------------------------------------------------------------------------
// clock_calendar_counter_top : real-time clock and calendar counter
// Each input word is one hundredth-second tick with the set buttons; each
// tick yields one output word with the full time and date.
//
// Input stream: tdata bit 0 button A, bit 1 button B, bit 2 button C;
// tuser bit 0 date mode (buttons set year/month/day, else hour/min/sec).
// Output stream: one word per tick, the counts after that tick.
// Configuration: cfg_valid/cfg_ready write channel, index 0 days in month,
// 1 start year, 2 last year; always ready, write only while idle.
//
// Results register in the output register, or the skid word on a stall.
// Throughput: one tick per cycle while s_axis_tready is high; the cascade is
// one pass of adders and compares between counter and output registers.
// Reset: time 12:00:00.00, date 7/6/1993, day limit 30, years 1993..2099,
// output empty.
// Receiver stall: a two-word output buffer takes one more tick, then
// s_axis_tready drops until the receiver takes a word.
// ----------------------------------------------------------------------------
module clock_calendar_counter_top
    import ccc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // button_a, button_b, button_c, zero pad
    input  logic [IN_USER_W-1:0]   s_axis_tuser,  // date_mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // hundredths, seconds_now, minutes_now,
                                                  // hours_now, day_now, month_now,
                                                  // year_now, zero pad
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    result_t result_next;
    result_t out_word;
    logic    tick;

    assign cfg_ready = 1'b1;
    assign tick      = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.days_in_month <= DAYS_IN_MONTH_RST;
            cfg_reg.year_start    <= YEAR_START_RST;
            cfg_reg.year_last     <= YEAR_LAST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DAYS_IN_MONTH: cfg_reg.days_in_month <= cfg_data[DAY_W-1:0];
                CFG_YEAR_START:    cfg_reg.year_start    <= cfg_data[YEAR_W-1:0];
                CFG_YEAR_LAST:     cfg_reg.year_last     <= cfg_data[YEAR_W-1:0];
                default:           ;
            endcase
        end
    end

    ccc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .date_mode   (s_axis_tuser[0]),
        .button_a    (s_axis_tdata[0]),
        .button_b    (s_axis_tdata[1]),
        .button_c    (s_axis_tdata[2]),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    ccc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (result_next),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-RESULT_W){1'b0}}, out_word};

endmodule

// ----- src/ccc_core.sv -----
// ----------------------------------------------------------------------------
// ccc_core : counter state and single-pass carry cascade
// Holds the time and date counts; on each tick applies the set buttons,
// advances the hundredths and runs one carry pass up to the year.
// ----------------------------------------------------------------------------
module ccc_core
    import ccc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick,
    input  logic    date_mode,
    input  logic    button_a,
    input  logic    button_b,
    input  logic    button_c,
    input  cfg_t    cfg,
    output result_t result_next
);

    logic [HUND_W-1:0]  hund_reg;
    logic [SEC_W-1:0]   sec_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [YEAR_W-1:0]  year_reg;

    logic bump_year, bump_month, bump_day;
    logic bump_hour, bump_min, bump_sec;

    logic [HUND_W:0]  hund_sum;
    logic [SEC_W:0]   sec_sum;
    logic [MIN_W:0]   min_sum;
    logic [HOUR_W:0]  hour_sum;
    logic [DAY_W:0]   day_sum;
    logic [MONTH_W:0] month_sum;
    logic [YEAR_W:0]  year_sum;

    logic hund_wrap, sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap, year_over;

    // first pressed button wins, A before B before C
    always_comb
    begin
        bump_year  = date_mode & button_a;
        bump_month = date_mode & ~button_a & button_b;
        bump_day   = date_mode & ~button_a & ~button_b & button_c;
        bump_hour  = ~date_mode & button_a;
        bump_min   = ~date_mode & ~button_a & button_b;
        bump_sec   = ~date_mode & ~button_a & ~button_b & button_c;
    end

    // sums carry one spare bit so a double bump still compares true
    always_comb
    begin
        hund_sum  = {1'b0, hund_reg} + (HUND_W+1)'(1);
        hund_wrap = hund_sum > {1'b0, HUND_MAX};

        sec_sum  = {1'b0, sec_reg} + (SEC_W+1)'(bump_sec) + (SEC_W+1)'(hund_wrap);
        sec_wrap = sec_sum > {1'b0, SEC_MAX};

        min_sum  = {1'b0, min_reg} + (MIN_W+1)'(bump_min) + (MIN_W+1)'(sec_wrap);
        min_wrap = min_sum > {1'b0, MIN_MAX};

        hour_sum  = {1'b0, hour_reg} + (HOUR_W+1)'(bump_hour) + (HOUR_W+1)'(min_wrap);
        hour_wrap = hour_sum > {1'b0, HOUR_MAX};

        day_sum  = {1'b0, day_reg} + (DAY_W+1)'(bump_day) + (DAY_W+1)'(hour_wrap);
        day_wrap = day_sum > {1'b0, cfg.days_in_month};

        month_sum  = {1'b0, month_reg} + (MONTH_W+1)'(bump_month) + (MONTH_W+1)'(day_wrap);
        month_wrap = month_sum > {1'b0, MONTH_MAX};

        year_sum  = {1'b0, year_reg} + (YEAR_W+1)'(bump_year) + (YEAR_W+1)'(month_wrap);
        year_over = year_sum > {1'b0, cfg.year_last};

        result_next.hundredths  = hund_wrap  ? '0 : hund_sum[HUND_W-1:0];
        result_next.seconds_now = sec_wrap   ? '0 : sec_sum[SEC_W-1:0];
        result_next.minutes_now = min_wrap   ? '0 : min_sum[MIN_W-1:0];
        result_next.hours_now   = hour_wrap  ? '0 : hour_sum[HOUR_W-1:0];
        result_next.day_now     = day_wrap   ? DAY_FIRST : day_sum[DAY_W-1:0];
        result_next.month_now   = month_wrap ? MONTH_FIRST : month_sum[MONTH_W-1:0];
        result_next.year_now    = year_over  ? cfg.year_start : year_sum[YEAR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hund_reg  <= HUND_RST;
            sec_reg   <= SEC_RST;
            min_reg   <= MIN_RST;
            hour_reg  <= HOUR_RST;
            day_reg   <= DAY_RST;
            month_reg <= MONTH_RST;
            year_reg  <= YEAR_RST;
        end
        else if (tick)
        begin
            hund_reg  <= result_next.hundredths;
            sec_reg   <= result_next.seconds_now;
            min_reg   <= result_next.minutes_now;
            hour_reg  <= result_next.hours_now;
            day_reg   <= result_next.day_now;
            month_reg <= result_next.month_now;
            year_reg  <= result_next.year_now;
        end
    end

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> (hund_reg <= HUND_MAX) && (sec_reg <= SEC_MAX)
                 && (min_reg <= MIN_MAX) && (hour_reg <= HOUR_MAX))
        else $error("time count out of range after tick");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> (month_reg >= MONTH_FIRST) && (month_reg <= MONTH_MAX))
        else $error("month count out of range after tick");

    a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> day_reg != '0)
        else $error("day count reached zero");

    a_year_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && year_over) |=> year_reg == $past(cfg.year_start))
        else $error("year not reloaded from start year");

endmodule

// ----- src/ccc_out_buf.sv -----
// ----------------------------------------------------------------------------
// ccc_out_buf : two-word output buffer
// Output register with a skid word behind it; upstream ready comes from a
// register, so the producer never waits on the receiver combinationally.
// ----------------------------------------------------------------------------
module ccc_out_buf
    import ccc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg, out_word_next;
    result_t skid_word_reg, skid_word_next;
    logic    push, pop;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        push            = in_valid & ~skid_valid_reg;
        pop             = out_valid_reg & out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_word_next  = in_word;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_word_next  = in_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_word_reg == $past(skid_word_reg))
                                          && !skid_valid_reg)
        else $error("skid word not moved to output");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_valid_reg) |=> out_valid_reg && (out_word_reg == $past(in_word)))
        else $error("accepted word lost on empty buffer");

endmodule
